/* sv/mqtt_session_keepalive_defines.svh */
// Assertion macros shared by the keepalive controller RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MQTT_SESSION_KEEPALIVE_DEFINES_SVH
`define MQTT_SESSION_KEEPALIVE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define MQTTKA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MQTTKA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mqttka_pkg.sv */
// Types, packet codes and helper functions of the keepalive controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mqttka_pkg;

    localparam int MS_PER_S = 1000;
    localparam logic [16:0] WAIT_MAX = 17'h1FFFF;
    localparam logic [15:0] INT_MS_MAX = 16'hFFFF;
    localparam logic [7:0] MISS_MAX = 8'hFF;

    localparam logic [7:0] PT_CONNECT = 8'h10;
    localparam logic [7:0] PT_SUBSCRIBE = 8'h82;
    localparam logic [7:0] PT_CONNACK = 8'h20;
    localparam logic [7:0] PT_SUBACK = 8'h90;
    localparam logic [7:0] PT_PINGRESP = 8'hD0;
    localparam logic [7:0] PT_PUBLISH = 8'h30;

    localparam logic [6:0] NORMAL_INT_RST = 7'd15;
    localparam logic [6:0] FAST_INT_RST = 7'd2;
    localparam logic [15:0] REPLY_TMO_RST = 16'd2000;
    localparam logic [7:0] GIVE_UP_RST = 8'd5;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_RX   = 2'd1,
        FUNC_TXQ  = 2'd2,
        FUNC_LINK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_NORMAL_INT = 2'd0,
        CFG_FAST_INT   = 2'd1,
        CFG_REPLY_TMO  = 2'd2,
        CFG_GIVE_UP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0]  normal_interval_s;
        logic [6:0]  fast_interval_s;
        logic [15:0] reply_timeout_ms;
        logic [7:0]  give_up_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] elapsed_ms;
        logic [7:0] packet_type;
        logic [7:0] return_code;
        logic       link_ok;
    } t_item;

    typedef struct packed {
        logic       send_ping;
        logic       link_dropped;
        logic       tx_allowed;
        logic       publish_received;
        logic       is_connected;
        logic       is_subscribed;
        logic [7:0] unanswered;
    } t_result;

    function automatic logic [15:0] secs_to_ms(input logic [6:0] secs);
        logic [16:0] ms;
        ms = 17'(secs) * 17'(MS_PER_S);
        return (ms > 17'(INT_MS_MAX)) ? INT_MS_MAX : ms[15:0];
    endfunction

endpackage

`default_nettype wire

/* sv/mqttka_cfg.sv */
// Configuration register file of the keepalive controller.
// Depends on mqttka_pkg for the register indexes and reset values.
`default_nettype none

module mqttka_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [1:0]        i_idx,
    input  wire logic [15:0]       i_data,
    output mqttka_pkg::t_cfg       o_cfg
);
    import mqttka_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_interval_s <= NORMAL_INT_RST;
            r_cfg.fast_interval_s <= FAST_INT_RST;
            r_cfg.reply_timeout_ms <= REPLY_TMO_RST;
            r_cfg.give_up_count <= GIVE_UP_RST;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_NORMAL_INT: r_cfg.normal_interval_s <= i_data[6:0];
                CFG_FAST_INT:   r_cfg.fast_interval_s <= i_data[6:0];
                CFG_REPLY_TMO:  r_cfg.reply_timeout_ms <= i_data;
                CFG_GIVE_UP:    r_cfg.give_up_count <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/mqttka_core.sv */
// Session state and per-request update logic of the keepalive controller.
// Depends on mqttka_pkg and the assertion macros header.
`default_nettype none
`include "mqtt_session_keepalive_defines.svh"

module mqttka_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire mqttka_pkg::t_item i_item,
    input  wire mqttka_pkg::t_cfg  i_cfg,
    output mqttka_pkg::t_result    o_res
);
    import mqttka_pkg::*;

    logic        r_conn, n_conn;
    logic        r_connack, n_connack;
    logic        r_sub, n_sub;
    logic        r_ping_en, n_ping_en;
    logic [15:0] r_int_ms, n_int_ms;
    logic [16:0] r_icnt, n_icnt;
    logic        r_ping_due, n_ping_due;
    logic [7:0]  r_miss, n_miss;
    logic [16:0] r_wait, n_wait;

    t_func       w_func;
    logic [16:0] w_icnt_sum;
    logic [17:0] w_wait_sum;
    logic [16:0] w_wait_sat;
    logic        w_ping;
    logic        w_tx;
    logic        w_pub;

    assign w_func = t_func'(i_item.func);
    assign w_icnt_sum = r_icnt + 17'(i_item.elapsed_ms);
    assign w_wait_sum = 18'(r_wait) + 18'(i_item.elapsed_ms);
    assign w_wait_sat = w_wait_sum[17] ? WAIT_MAX : w_wait_sum[16:0];

    always_comb begin
        n_conn = r_conn;
        n_connack = r_connack;
        n_sub = r_sub;
        n_ping_en = r_ping_en;
        n_int_ms = r_int_ms;
        n_icnt = r_icnt;
        n_ping_due = r_ping_due;
        n_miss = r_miss;
        n_wait = r_wait;
        w_ping = 1'b0;
        w_tx = 1'b0;
        w_pub = 1'b0;
        case (w_func)
            FUNC_TICK: begin
                if (r_ping_en) begin
                    if (w_icnt_sum >= 17'(r_int_ms)) begin
                        n_icnt = '0;
                        n_ping_due = 1'b1;
                    end else begin
                        n_icnt = w_icnt_sum;
                    end
                end else begin
                    n_icnt = '0;
                end
                if (r_miss != '0) begin
                    n_wait = w_wait_sat;
                end
                if (n_ping_due || (n_wait > 17'(i_cfg.reply_timeout_ms))) begin
                    n_ping_due = 1'b0;
                    n_wait = '0;
                    if (r_miss == i_cfg.give_up_count) begin
                        n_conn = 1'b0;
                        n_ping_en = 1'b0;
                    end else if (r_miss == 8'd0) begin
                        w_ping = 1'b1;
                    end else if (r_miss == 8'd1) begin
                        n_int_ms = secs_to_ms(i_cfg.fast_interval_s);
                        n_icnt = '0;
                        n_ping_en = 1'b1;
                        w_ping = 1'b1;
                    end else if (r_miss < i_cfg.give_up_count) begin
                        w_ping = 1'b1;
                    end
                    if (r_miss != MISS_MAX) begin
                        n_miss = r_miss + 8'd1;
                    end
                end
            end
            FUNC_RX: begin
                if (r_conn) begin
                    if (i_item.packet_type == PT_CONNACK) begin
                        if (i_item.return_code == 8'd0) begin
                            n_connack = 1'b1;
                        end else begin
                            n_conn = 1'b0;
                        end
                    end else if (i_item.packet_type == PT_SUBACK) begin
                        if (i_item.return_code <= 8'd1) begin
                            n_sub = 1'b1;
                            n_miss = '0;
                            n_int_ms = secs_to_ms(i_cfg.normal_interval_s);
                            n_icnt = '0;
                            n_ping_en = 1'b1;
                        end else begin
                            n_conn = 1'b0;
                        end
                    end else if (i_item.packet_type == PT_PINGRESP) begin
                        if (r_miss == 8'd1) begin
                            n_miss = '0;
                        end else if (r_miss > 8'd1) begin
                            n_miss = '0;
                            n_int_ms = secs_to_ms(i_cfg.normal_interval_s);
                            n_icnt = '0;
                            n_ping_en = 1'b1;
                        end
                    end else if (i_item.packet_type == PT_PUBLISH) begin
                        w_pub = 1'b1;
                    end
                end
            end
            FUNC_TXQ: begin
                w_tx = r_conn && ((i_item.packet_type == PT_CONNECT) ||
                                  ((i_item.packet_type == PT_SUBSCRIBE) && r_connack) ||
                                  r_sub);
            end
            FUNC_LINK: begin
                if (!r_conn) begin
                    n_ping_en = 1'b0;
                    if (i_item.link_ok) begin
                        n_conn = 1'b1;
                        n_connack = 1'b0;
                        n_sub = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn <= 1'b0;
            r_connack <= 1'b0;
            r_sub <= 1'b0;
            r_ping_en <= 1'b0;
            r_int_ms <= '0;
            r_icnt <= '0;
            r_ping_due <= 1'b0;
            r_miss <= '0;
            r_wait <= '0;
        end else if (i_fire) begin
            r_conn <= n_conn;
            r_connack <= n_connack;
            r_sub <= n_sub;
            r_ping_en <= n_ping_en;
            r_int_ms <= n_int_ms;
            r_icnt <= n_icnt;
            r_ping_due <= n_ping_due;
            r_miss <= n_miss;
            r_wait <= n_wait;
        end
    end

    always_comb begin
        o_res.send_ping = w_ping;
        o_res.link_dropped = r_conn && !n_conn;
        o_res.tx_allowed = w_tx;
        o_res.publish_received = w_pub;
        o_res.is_connected = n_conn;
        o_res.is_subscribed = n_sub;
        o_res.unanswered = n_miss;
    end

    // A pending ping is always consumed by the escalation step of the same tick.
    `MQTTKA_ASSERT(a_no_stale_ping_due, i_clk, i_rst_n, !r_ping_due,
        "ping_due left pending")
    `MQTTKA_ASSERT(a_ping_only_on_tick, i_clk, i_rst_n, w_ping |-> (w_func == FUNC_TICK),
        "ping requested outside a tick")
    `MQTTKA_ASSERT(a_tick_miss_monotonic, i_clk, i_rst_n,
        (i_fire && (w_func == FUNC_TICK)) |=> (r_miss >= $past(r_miss)),
        "miss count fell on a tick")

endmodule

`default_nettype wire

/* sv/mqtt_session_keepalive.sv */
// Top level of the MQTT client keepalive and session controller.
// Instantiates mqttka_cfg and mqttka_core; depends on mqttka_pkg and the macros header.
//
// Requests enter on the input channel (i_valid / o_ready) as one of four kinds:
// a time tick, a received packet header, a transmit gate query or a link attempt
// result. Each request yields exactly one result on the output channel
// (o_valid / i_ready) carrying the ping request, link drop, gate answer, publish
// flag and the current session state.
// The path is an input register, the state update logic and a result register;
// an accepted request moves into the result register when the output side is
// free. One request is taken per cycle for as long as the output side keeps
// taking results; the session state updates in the cycle a request moves into
// the result register.
// When the receiver stalls, the result holds, one more request waits in the
// input register, and o_ready then drops until the result is taken.
// Synchronous active-low reset clears the session state, restores the register
// defaults (15 s, 2 s, 2000 ms, give up at 5) and empties both stages. The user must
// write registers via i_cfg_we / i_cfg_idx / i_cfg_data only while idle; unenforced.
`default_nettype none
`include "mqtt_session_keepalive_defines.svh"

module mqtt_session_keepalive (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_elapsed_ms,
    input  wire logic [7:0]  i_packet_type,
    input  wire logic [7:0]  i_return_code,
    input  wire logic        i_link_ok,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_send_ping,
    output logic             o_link_dropped,
    output logic             o_tx_allowed,
    output logic             o_publish_received,
    output logic             o_is_connected,
    output logic             o_is_subscribed,
    output logic [7:0]       o_unanswered
);
    import mqttka_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result w_res;
    t_result r_res;
    logic    r_out_vld;
    logic    w_out_free;
    logic    w_fire;
    logic    w_accept;

    assign w_out_free = !r_out_vld || i_ready;
    assign w_fire = r_in_vld && w_out_free;
    assign o_ready = !r_in_vld || w_out_free;
    assign w_accept = i_valid && o_ready;

    mqttka_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    mqttka_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.func <= i_func;
            r_item.elapsed_ms <= i_elapsed_ms;
            r_item.packet_type <= i_packet_type;
            r_item.return_code <= i_return_code;
            r_item.link_ok <= i_link_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_send_ping = r_res.send_ping;
    assign o_link_dropped = r_res.link_dropped;
    assign o_tx_allowed = r_res.tx_allowed;
    assign o_publish_received = r_res.publish_received;
    assign o_is_connected = r_res.is_connected;
    assign o_is_subscribed = r_res.is_subscribed;
    assign o_unanswered = r_res.unanswered;

    `MQTTKA_ASSERT(a_accept_fills_input, i_clk, i_rst_n, w_accept |=> r_in_vld,
        "accepted request lost")
    `MQTTKA_ASSERT(a_fire_fills_output, i_clk, i_rst_n, w_fire |=> r_out_vld,
        "processed request produced no result")
    `MQTTKA_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (r_in_vld && r_out_vld && !i_ready) |-> !o_ready,
        "request taken with both stages full")

endmodule

`default_nettype wire
